[sv/dmc_pkg.sv]
package dmc_pkg;

  // Default grid size
  localparam int MAX_COLS_DEF = 32;
  localparam int MAX_ROWS_DEF = 16;

  // Width that the area limits are compared in (covers up to 127 columns or rows)
  localparam int AREA_W = 7;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_CARVE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_E = 2'd1;
  localparam logic [1:0] DIR_S = 2'd2;
  localparam logic [1:0] DIR_W = 2'd3;

  localparam logic [1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IDX_HEIGHT = 2'd1;

  localparam logic [5:0] WIDTH_RST  = 6'd21;
  localparam logic [4:0] HEIGHT_RST = 5'd15;

  localparam logic [3:0] ALL_WALLS = 4'hF;

  typedef struct packed {
    logic [1:0]  command;
    logic [4:0]  cell_col;
    logic [3:0]  cell_row;
    logic [15:0] random_value;
  } in_beat_t;

  typedef struct packed {
    logic [4:0] from_col;
    logic [3:0] from_row;
    logic [1:0] direction;
    logic       carved;
    logic       done_res;
    logic [3:0] wall_bits;
    logic       bad_coordinate;
  } out_beat_t;

  typedef struct packed {
    logic       visited;
    logic [3:0] walls;
  } cell_word_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } stack_op_t;

  function automatic logic [3:0] wall_mask(logic [1:0] dir);
    logic [3:0] m;
    m = '0;
    unique case (dir)
      DIR_N: m = 4'b0001;
      DIR_E: m = 4'b0010;
      DIR_S: m = 4'b0100;
      DIR_W: m = 4'b1000;
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [3:0] opp_mask(logic [1:0] dir);
    logic [3:0] m;
    m = '0;
    unique case (dir)
      DIR_N: m = 4'b0100;
      DIR_E: m = 4'b1000;
      DIR_S: m = 4'b0001;
      DIR_W: m = 4'b0010;
      default: m = '0;
    endcase
    return m;
  endfunction

  // rnd mod cnt for cnt in 1..4; mod 3 by digit sum in base 4, as 4 == 1 (mod 3)
  function automatic logic [1:0] pick_slot(logic [15:0] rnd, logic [2:0] cnt);
    logic [4:0] s;
    logic [2:0] t;
    logic [1:0] r;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 5'(rnd[2*i +: 2]);
    end
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    if (t >= 3'd6) begin
      t = t - 3'd6;
    end else if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    case (cnt)
      3'd2:    r = {1'b0, rnd[0]};
      3'd3:    r = t[1:0];
      3'd4:    r = rnd[1:0];
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

[sv/dmc_cell_mem.sv]
module dmc_cell_mem #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  dmc_pkg::cell_word_t wdata_i,
  input  logic                re_i,
  input  logic [AW-1:0]       raddr_i,
  output dmc_pkg::cell_word_t rdata_o
);
  import dmc_pkg::*;

  cell_word_t mem_q [DEPTH];
  cell_word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/dmc_stack.sv]
module dmc_stack #(
  parameter int ENTRY_W = 9,
  parameter int DEPTH   = 512
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dmc_pkg::stack_op_t op_i,
  input  logic [ENTRY_W-1:0] wdata_i,
  input  logic               rd_i,
  output logic [ENTRY_W-1:0] rdata_o,
  output logic               empty_o,
  output logic               last_o,
  output logic               full_o
);
  import dmc_pkg::*;

  localparam int DW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  logic [ENTRY_W-1:0] mem_q [DEPTH];
  logic [ENTRY_W-1:0] rdata_q;
  logic [DW-1:0]      depth_q, depth_d;
  logic [DW-1:0]      top_w;

  assign top_w = depth_q - DW'(1);

  always_comb begin
    depth_d = depth_q;
    if (op_i.clear) begin
      depth_d = '0;
    end else if (op_i.push) begin
      depth_d = depth_q + DW'(1);
    end else if (op_i.pop) begin
      depth_d = top_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
    end else begin
      depth_q <= depth_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i.push && !op_i.clear) begin
      mem_q[depth_q[IW-1:0]] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i) begin
      rdata_q <= mem_q[top_w[IW-1:0]];
    end
  end

  assign rdata_o = rdata_q;
  assign empty_o = (depth_q == '0);
  assign last_o  = (depth_q == DW'(1));
  assign full_o  = (depth_q == DW'(DEPTH));

endmodule

[sv/dmc_nbr_unit.sv]
module dmc_nbr_unit #(
  parameter int COL_W = 5,
  parameter int ROW_W = 4
) (
  input  logic [COL_W-1:0]           cur_col_i,
  input  logic [ROW_W-1:0]           cur_row_i,
  input  logic [1:0]                 dir_i,
  input  logic [dmc_pkg::AREA_W-1:0] eff_w_i,
  input  logic [dmc_pkg::AREA_W-1:0] eff_h_i,
  output logic [COL_W-1:0]           nb_col_o,
  output logic [ROW_W-1:0]           nb_row_o,
  output logic                       ok_o
);
  import dmc_pkg::*;

  logic [COL_W:0] col_x;
  logic [ROW_W:0] row_x;
  logic           low_edge;

  always_comb begin
    col_x    = {1'b0, cur_col_i};
    row_x    = {1'b0, cur_row_i};
    low_edge = 1'b0;
    unique case (dir_i)
      DIR_N: begin
        low_edge = (cur_row_i == '0);
        row_x    = row_x - (ROW_W + 1)'(1);
      end
      DIR_E: col_x = col_x + (COL_W + 1)'(1);
      DIR_S: row_x = row_x + (ROW_W + 1)'(1);
      DIR_W: begin
        low_edge = (cur_col_i == '0);
        col_x    = col_x - (COL_W + 1)'(1);
      end
      default: low_edge = 1'b1;
    endcase
  end

  // the wrapped value on the low edge is masked by low_edge
  assign ok_o     = !low_edge && (AREA_W'(col_x) < eff_w_i) && (AREA_W'(row_x) < eff_h_i);
  assign nb_col_o = col_x[COL_W-1:0];
  assign nb_row_o = row_x[ROW_W-1:0];

endmodule

[sv/dfs_maze_carver_core.sv]
// Channel  Direction  Handshake                Beat
// in       input      in_valid_i / in_stall_o  in_data_i  (command, cell, random word)
// out      output     out_valid_o / out_stall_i out_data_o (one result per input beat)
// cfg      input      cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// One beat at a time; in_stall_o is high from acceptance until the result is in
// the output register. A start runs the clearing sweep, one cell per cycle. A carve
// does, per stack cell examined, one stack read and up to five cell reads (in-area
// neighbours, then the top cell), then carves a wall or pops the cell. After reset
// the sweep runs over all MAX_COLS*MAX_ROWS cells (512 by default) with in_stall_o
// high. A stalled result holds the sequencer before it loads the next.
module dfs_maze_carver_core #(
  parameter int MAX_COLS = dmc_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = dmc_pkg::MAX_ROWS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dmc_pkg::in_beat_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output dmc_pkg::out_beat_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [5:0]        cfg_wdata_i
);
  import dmc_pkg::*;

  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int ENTRY_W    = COL_W + ROW_W;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b000000000001,
    S_CLEAR   = 12'b000000000010,
    S_START   = 12'b000000000100,
    S_READ    = 12'b000000001000,
    S_RD_WAIT = 12'b000000010000,
    S_FETCH   = 12'b000000100000,
    S_TOP     = 12'b000001000000,
    S_SCAN    = 12'b000010000000,
    S_PICK    = 12'b000100000000,
    S_WR_CUR  = 12'b001000000000,
    S_WR_NB   = 12'b010000000000,
    S_RESP    = 12'b100000000000
  } state_e;

  function automatic logic [AW-1:0] cell_addr(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    return AW'(AW'(r) * AW'(MAX_COLS)) + AW'(c);
  endfunction

  state_e          state_q, state_d;
  logic            boot_q, boot_d;
  in_beat_t        in_q, in_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic [2:0]      scan_q, scan_d;
  logic [3:0]      ok_q, ok_d;
  logic [3:0]      cand_q, cand_d;
  logic [3:0][3:0] nbw_q, nbw_d;
  cell_word_t      cur_q, cur_d;
  logic [COL_W-1:0] cur_col_q, cur_col_d;
  logic [ROW_W-1:0] cur_row_q, cur_row_d;
  logic [1:0]      dir_q, dir_d;
  out_beat_t       res_q, res_d;
  out_beat_t       out_q, out_d;
  logic            out_valid_q, out_valid_d;
  logic [5:0]      width_q;
  logic [4:0]      height_q;

  logic [AREA_W-1:0] eff_w, eff_h;
  logic              start_ok;
  logic [COL_W-1:0]  in_col;
  logic [ROW_W-1:0]  in_row;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  cell_word_t        mem_wdata, mem_rdata;

  stack_op_t         stk_op;
  logic [ENTRY_W-1:0] stk_wdata, stk_rdata;
  logic              stk_rd, stk_empty, stk_last, stk_full;

  logic [1:0]        nb_dir;
  logic [COL_W-1:0]  nb_col;
  logic [ROW_W-1:0]  nb_row;
  logic              nb_ok;

  logic [2:0]        cand_cnt;
  logic [1:0]        slot, pick_dir, seen, cap_idx;

  // area limits: zero acts as one, anything above the grid acts as the grid
  always_comb begin
    if (width_q == '0) begin
      eff_w = AREA_W'(1);
    end else if (AREA_W'(width_q) > AREA_W'(MAX_COLS)) begin
      eff_w = AREA_W'(MAX_COLS);
    end else begin
      eff_w = AREA_W'(width_q);
    end
    if (height_q == '0) begin
      eff_h = AREA_W'(1);
    end else if (AREA_W'(height_q) > AREA_W'(MAX_ROWS)) begin
      eff_h = AREA_W'(MAX_ROWS);
    end else begin
      eff_h = AREA_W'(height_q);
    end
  end

  assign start_ok = (AREA_W'(in_q.cell_col) < eff_w) && (AREA_W'(in_q.cell_row) < eff_h);
  assign in_col   = COL_W'(in_q.cell_col);
  assign in_row   = ROW_W'(in_q.cell_row);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_IDX_WIDTH) begin
        width_q <= cfg_wdata_i;
      end else if (cfg_idx_i == CFG_IDX_HEIGHT) begin
        height_q <= cfg_wdata_i[4:0];
      end
    end
  end

  assign nb_dir = (state_q == S_WR_NB) ? dir_q : scan_q[1:0];

  dmc_nbr_unit #(
    .COL_W (COL_W),
    .ROW_W (ROW_W)
  ) u_nbr (
    .cur_col_i (cur_col_q),
    .cur_row_i (cur_row_q),
    .dir_i     (nb_dir),
    .eff_w_i   (eff_w),
    .eff_h_i   (eff_h),
    .nb_col_o  (nb_col),
    .nb_row_o  (nb_row),
    .ok_o      (nb_ok)
  );

  dmc_cell_mem #(
    .DEPTH (CELL_COUNT),
    .AW    (AW)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  dmc_stack #(
    .ENTRY_W (ENTRY_W),
    .DEPTH   (CELL_COUNT)
  ) u_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_i    (stk_op),
    .wdata_i (stk_wdata),
    .rd_i    (stk_rd),
    .rdata_o (stk_rdata),
    .empty_o (stk_empty),
    .last_o  (stk_last),
    .full_o  (stk_full)
  );

  // candidate count and choice of the slot-th unvisited neighbour
  always_comb begin
    cand_cnt = '0;
    for (int i = 0; i < 4; i++) begin
      cand_cnt = cand_cnt + 3'(cand_q[i]);
    end
    slot     = pick_slot(in_q.random_value, cand_cnt);
    pick_dir = DIR_N;
    seen     = '0;
    for (int i = 0; i < 4; i++) begin
      if (cand_q[i]) begin
        if (seen == slot) begin
          pick_dir = 2'(i);
        end
        seen = seen + 2'd1;
      end
    end
  end

  assign cap_idx    = 2'(scan_q - 3'd1);
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d   = state_q;
    boot_d    = boot_q;
    in_d      = in_q;
    clr_d     = clr_q;
    scan_d    = scan_q;
    ok_d      = ok_q;
    cand_d    = cand_q;
    nbw_d     = nbw_q;
    cur_d     = cur_q;
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    dir_d     = dir_q;
    res_d     = res_q;
    out_d     = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = '{visited: 1'b0, walls: ALL_WALLS};
    mem_re    = 1'b0;
    mem_raddr = cell_addr(nb_row, nb_col);
    stk_op    = '0;
    stk_wdata = {nb_row, nb_col};
    stk_rd    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          in_d  = in_data_i;
          res_d = '0;
          unique case (in_data_i.command)
            CMD_START: begin
              clr_d        = '0;
              stk_op.clear = 1'b1;
              state_d      = S_CLEAR;
            end
            CMD_CARVE: begin
              if (stk_empty) begin
                res_d.done_res = 1'b1;
                state_d        = S_RESP;
              end else begin
                state_d = S_FETCH;
              end
            end
            CMD_READ: state_d = S_READ;
            default:  state_d = S_RESP;
          endcase
        end
      end
      S_CLEAR: begin
        mem_we = 1'b1;
        clr_d  = clr_q + AW'(1);
        if (clr_q == AW'(CELL_COUNT - 1)) begin
          if (boot_q) begin
            boot_d  = 1'b0;
            state_d = S_IDLE;
          end else begin
            state_d = S_START;
          end
        end
      end
      S_START: begin
        res_d.from_col = in_q.cell_col;
        res_d.from_row = in_q.cell_row;
        if (start_ok) begin
          mem_we      = 1'b1;
          mem_waddr   = cell_addr(in_row, in_col);
          mem_wdata   = '{visited: 1'b1, walls: ALL_WALLS};
          stk_op.push = 1'b1;
          stk_wdata   = {in_row, in_col};
        end else begin
          res_d.bad_coordinate = 1'b1;
          res_d.done_res       = 1'b1;
        end
        state_d = S_RESP;
      end
      S_READ: begin
        if (start_ok) begin
          mem_re    = 1'b1;
          mem_raddr = cell_addr(in_row, in_col);
          state_d   = S_RD_WAIT;
        end else begin
          res_d.bad_coordinate = 1'b1;
          state_d              = S_RESP;
        end
      end
      S_RD_WAIT: begin
        res_d.wall_bits = mem_rdata.walls;
        state_d         = S_RESP;
      end
      S_FETCH: begin
        stk_rd  = 1'b1;
        state_d = S_TOP;
      end
      S_TOP: begin
        cur_col_d = stk_rdata[COL_W-1:0];
        cur_row_d = stk_rdata[ENTRY_W-1:COL_W];
        scan_d    = '0;
        state_d   = S_SCAN;
      end
      S_SCAN: begin
        // read in-area N, E, S, W, then the top cell; data lands the next cycle
        if (scan_q < 3'd4) begin
          mem_re             = nb_ok;
          ok_d[scan_q[1:0]]  = nb_ok;
        end else if (scan_q == 3'd4) begin
          mem_re    = 1'b1;
          mem_raddr = cell_addr(cur_row_q, cur_col_q);
        end
        if (scan_q != 3'd0 && scan_q <= 3'd4) begin
          cand_d[cap_idx] = ok_q[cap_idx] && !mem_rdata.visited;
          nbw_d[cap_idx]  = mem_rdata.walls;
        end
        scan_d = scan_q + 3'd1;
        if (scan_q == 3'd5) begin
          cur_d   = mem_rdata;
          state_d = S_PICK;
        end
      end
      S_PICK: begin
        if (cand_cnt == '0) begin
          stk_op.pop = 1'b1;
          if (stk_last) begin
            res_d.done_res = 1'b1;
            state_d        = S_RESP;
          end else begin
            state_d = S_FETCH;
          end
        end else begin
          dir_d   = pick_dir;
          state_d = S_WR_CUR;
        end
      end
      S_WR_CUR: begin
        mem_we    = 1'b1;
        mem_waddr = cell_addr(cur_row_q, cur_col_q);
        mem_wdata = '{visited: cur_q.visited, walls: cur_q.walls & ~wall_mask(dir_q)};
        state_d   = S_WR_NB;
      end
      S_WR_NB: begin
        mem_we      = 1'b1;
        mem_waddr   = cell_addr(nb_row, nb_col);
        mem_wdata   = '{visited: 1'b1, walls: nbw_q[dir_q] & ~opp_mask(dir_q)};
        stk_op.push = !stk_full;
        res_d.from_col  = 5'(cur_col_q);
        res_d.from_row  = 4'(cur_row_q);
        res_d.direction = dir_q;
        res_d.carved    = 1'b1;
        state_d         = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      boot_q      <= 1'b1;
      clr_q       <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      boot_q      <= boot_d;
      clr_q       <= clr_d;
      scan_q      <= scan_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q      <= in_d;
    ok_q      <= ok_d;
    cand_q    <= cand_d;
    nbw_q     <= nbw_d;
    cur_q     <= cur_d;
    cur_col_q <= cur_col_d;
    cur_row_q <= cur_row_d;
    dir_q     <= dir_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[dv/testbench.sv]
module testbench;
  import dmc_pkg::*;

  localparam int GRID_COLS = MAX_COLS_DEF;
  localparam int GRID_ROWS = MAX_ROWS_DEF;
  localparam int GRID_CELLS = GRID_COLS * GRID_ROWS;
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int TARGET_BEATS = 1050;
  localparam int SETTLE_CYCLES = 600;
  localparam int HOLDOFF_CYCLES = 400;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_beat_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_beat_t out_data_o;
  logic      cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [5:0] cfg_wdata_i;

  // maze mirror
  logic [3:0] wall_mirror [GRID_CELLS];
  bit         seen_mirror [GRID_CELLS];
  int         trail [$];
  logic [5:0] cols_reg = WIDTH_RST;
  logic [4:0] rows_reg = HEIGHT_RST;

  in_beat_t  pending_q [$];
  out_beat_t expected_q [$];

  bit in_accepted = 1'b0;
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int holdoff_left = 0;
  int mismatches = 0;
  int beats_queued = 0;
  int beats_in = 0;
  int results_seen = 0;
  int carved_seen = 0;
  int done_seen = 0;
  int bad_seen = 0;
  int area_settings = 0;

  dfs_maze_carver_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic int cols_live(logic [5:0] w);
    if (w == 0) return 1;
    if (w > GRID_COLS) return GRID_COLS;
    return int'(w);
  endfunction

  function automatic int rows_live(logic [4:0] h);
    if (h == 0) return 1;
    if (h > GRID_ROWS) return GRID_ROWS;
    return int'(h);
  endfunction

  function automatic bit on_grid(int c, int r);
    return c >= 0 && r >= 0 && c < cols_live(cols_reg) && r < rows_live(rows_reg);
  endfunction

  function automatic void step_to(int cc, int cr, int d, output int nc, output int nr);
    case (2'(d))
      DIR_N: begin nc = cc;     nr = cr - 1; end
      DIR_E: begin nc = cc + 1; nr = cr;     end
      DIR_S: begin nc = cc;     nr = cr + 1; end
      default: begin nc = cc - 1; nr = cr; end
    endcase
  endfunction

  // one beat through the maze mirror; returns the result it should give
  function automatic out_beat_t advance_maze(in_beat_t beat);
    out_beat_t res;
    int cur, cc, cr, nc, nr, cnt, pick, nidx, idx;
    int opts [4];
    bit placed;
    res = '0;
    placed = 1'b0;
    idx = int'(beat.cell_row) * GRID_COLS + int'(beat.cell_col);
    case (beat.command)
      CMD_START: begin
        foreach (wall_mirror[i]) wall_mirror[i] = ALL_WALLS;
        foreach (seen_mirror[i]) seen_mirror[i] = 1'b0;
        trail.delete();
        res.from_col = beat.cell_col;
        res.from_row = beat.cell_row;
        if (!on_grid(beat.cell_col, beat.cell_row)) begin
          res.bad_coordinate = 1'b1;
          res.done_res = 1'b1;
        end else begin
          seen_mirror[idx] = 1'b1;
          trail.push_back(idx);
        end
      end
      CMD_CARVE: begin
        while (trail.size() > 0 && !placed) begin
          cur = trail[$];
          cc = cur % GRID_COLS;
          cr = cur / GRID_COLS;
          cnt = 0;
          for (int d = 0; d < 4; d++) begin
            step_to(cc, cr, d, nc, nr);
            if (on_grid(nc, nr) && !seen_mirror[nr * GRID_COLS + nc]) begin
              opts[cnt] = d;
              cnt++;
            end
          end
          if (cnt == 0) begin
            void'(trail.pop_back());
          end else begin
            pick = opts[int'(beat.random_value) % cnt];
            step_to(cc, cr, pick, nc, nr);
            nidx = nr * GRID_COLS + nc;
            wall_mirror[cur] &= ~(4'b0001 << pick);
            wall_mirror[nidx] &= ~(4'b0001 << ((pick + 2) % 4));
            seen_mirror[nidx] = 1'b1;
            if (trail.size() < GRID_CELLS) trail.push_back(nidx);
            res.from_col = 5'(cc);
            res.from_row = 4'(cr);
            res.direction = 2'(pick);
            res.carved = 1'b1;
            placed = 1'b1;
          end
        end
        if (!placed) res.done_res = 1'b1;
      end
      CMD_READ: begin
        if (!on_grid(beat.cell_col, beat.cell_row)) res.bad_coordinate = 1'b1;
        else res.wall_bits = wall_mirror[idx];
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string field, int unsigned want, int unsigned got);
    if (mismatches < 40) begin
      $display("%0t: result %0d %s: expected %0h, got %0h", $time, results_seen, field, want, got);
    end
    mismatches++;
  endtask

  // sender: one beat offered at a time, held until taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_accepted) begin
      if (pending_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall, with a counted hold-off when asked
  always @(negedge clk_i) begin
    if (holdoff_left > 0) begin
      out_stall_i <= 1'b1;
      holdoff_left <= holdoff_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    out_beat_t want;
    in_accepted = rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_WIDTH: cols_reg = cfg_wdata_i;
        CFG_IDX_HEIGHT: rows_reg = cfg_wdata_i[4:0];
        default: ;
      endcase
    end
    if (in_accepted) begin
      expected_q.push_back(advance_maze(in_data_i));
      beats_in++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat", 0, out_data_o);
      end else begin
        want = expected_q.pop_front();
        if (out_data_o.from_col !== want.from_col)
          report_mismatch("from_col", want.from_col, out_data_o.from_col);
        if (out_data_o.from_row !== want.from_row)
          report_mismatch("from_row", want.from_row, out_data_o.from_row);
        if (out_data_o.direction !== want.direction)
          report_mismatch("direction", want.direction, out_data_o.direction);
        if (out_data_o.carved !== want.carved)
          report_mismatch("carved", want.carved, out_data_o.carved);
        if (out_data_o.done_res !== want.done_res)
          report_mismatch("done_res", want.done_res, out_data_o.done_res);
        if (out_data_o.wall_bits !== want.wall_bits)
          report_mismatch("wall_bits", want.wall_bits, out_data_o.wall_bits);
        if (out_data_o.bad_coordinate !== want.bad_coordinate)
          report_mismatch("bad_coordinate", want.bad_coordinate, out_data_o.bad_coordinate);
        if (want.carved) carved_seen++;
        if (want.done_res) done_seen++;
        if (want.bad_coordinate) bad_seen++;
      end
    end
  end

  task automatic queue_beat(logic [1:0] cmd, int col, int row, int rnd);
    in_beat_t b;
    b.command = cmd;
    b.cell_col = 5'(col);
    b.cell_row = 4'(row);
    b.random_value = 16'(rnd);
    pending_q.push_back(b);
    beats_queued++;
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || in_valid_i || expected_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // block idle: write both area registers, then pick the idling for the next phase
  task automatic new_phase(int w, int h, int sender_pct, int stall_p);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_IDX_WIDTH;
    cfg_wdata_i <= 6'(w);
    @(negedge clk_i);
    cfg_idx_i <= CFG_IDX_HEIGHT;
    cfg_wdata_i <= 6'(h);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sender_idle_pct = sender_pct;
    stall_pct = stall_p;
    area_settings++;
  endtask

  initial begin
    int kind, w, h, ew, eh, carves, session, s_pct, r_pct;
    bit fresh;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_IDX_WIDTH;
    cfg_wdata_i = '0;
    foreach (wall_mirror[i]) wall_mirror[i] = ALL_WALLS;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset area: untouched store, out-of-area read, spare command, empty stack, bad start, a short maze
    queue_beat(CMD_READ, 0, 0, 0);
    queue_beat(CMD_READ, 31, 15, 0);
    queue_beat(CMD_SPARE, 31, 15, 16'hFFFF);
    queue_beat(CMD_CARVE, 0, 0, 0);
    queue_beat(CMD_START, 25, 3, 0);
    queue_beat(CMD_CARVE, 0, 0, 16'h7777);
    queue_beat(CMD_START, 20, 14, 0);
    queue_beat(CMD_CARVE, 0, 0, 16'hFFFF);
    queue_beat(CMD_CARVE, 0, 0, 16'h0000);
    queue_beat(CMD_CARVE, 0, 0, 16'h5555);
    queue_beat(CMD_READ, 20, 14, 0);

    // register values above range clamp to the full grid
    new_phase(63, 31, 0, 0);
    queue_beat(CMD_START, 31, 15, 0);
    queue_beat(CMD_CARVE, 0, 0, 16'hAAAA);
    queue_beat(CMD_CARVE, 0, 0, 16'h1234);
    queue_beat(CMD_READ, 31, 15, 0);
    queue_beat(CMD_READ, 0, 0, 0);

    // zero acts as one; stacked cells now lie outside the area
    new_phase(0, 0, 0, 0);
    queue_beat(CMD_CARVE, 0, 0, 16'h0003);
    queue_beat(CMD_START, 0, 0, 0);
    queue_beat(CMD_CARVE, 0, 0, 16'h0001);
    queue_beat(CMD_READ, 1, 0, 0);

    new_phase(4, 4, 0, 0);
    queue_beat(CMD_START, 3, 3, 0);
    queue_beat(CMD_CARVE, 0, 0, $urandom_range(0, 65535));
    queue_beat(CMD_CARVE, 0, 0, $urandom_range(0, 65535));

    // shrink mid-maze
    new_phase(2, 2, 0, 0);
    repeat (3) queue_beat(CMD_CARVE, 0, 0, $urandom_range(0, 65535));

    session = 0;
    while (beats_queued < TARGET_BEATS) begin
      kind = $urandom_range(0, 19);
      case (session % 4)
        0: begin s_pct = 0;  r_pct = 0;  end
        1: begin s_pct = 88; r_pct = 0;  end
        2: begin s_pct = 0;  r_pct = 88; end
        default: begin s_pct = 31; r_pct = 31; end
      endcase
      if (kind < 3) begin
        w = $urandom_range(9, 63);
        h = $urandom_range(7, 31);
      end else begin
        w = $urandom_range(0, 8);
        h = $urandom_range(0, 6);
      end
      new_phase(w, h, s_pct, r_pct);
      if (session == 4) holdoff_left = HOLDOFF_CYCLES;
      ew = cols_live(6'(w));
      eh = rows_live(5'(h));
      fresh = !(kind >= 3 && kind < 6);
      if (kind < 3) carves = $urandom_range(20, 60);
      else if (!fresh) carves = $urandom_range(2, 12);
      else carves = ew * eh + 1;
      if (fresh) begin
        if ($urandom_range(9) == 0)
          queue_beat(CMD_START, $urandom_range(0, 31), $urandom_range(0, 15), 0);
        else
          queue_beat(CMD_START, $urandom_range(0, ew - 1), $urandom_range(0, eh - 1), 0);
      end
      repeat (carves) begin
        if ($urandom_range(9) == 0) begin
          if ($urandom_range(3) == 0)
            queue_beat(CMD_READ, $urandom_range(0, 31), $urandom_range(0, 15),
                       $urandom_range(0, 65535));
          else
            queue_beat(CMD_READ, $urandom_range(0, ew - 1), $urandom_range(0, eh - 1), 0);
        end
        if ($urandom_range(49) == 0)
          queue_beat(CMD_SPARE, $urandom_range(0, 31), $urandom_range(0, 15),
                     $urandom_range(0, 65535));
        if ($urandom_range(149) == 0)
          queue_beat(CMD_START, $urandom_range(0, 31), $urandom_range(0, 15), 0);
        queue_beat(CMD_CARVE, $urandom_range(0, 31), $urandom_range(0, 15),
                   $urandom_range(0, 65535));
      end
      session++;
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Ran %0d beats over %0d area settings and %0d mazes' worth of carving steps:",
             beats_in, area_settings, session);
    $display("  %0d walls carved, %0d done results, %0d bad coordinates flagged",
             carved_seen, done_seen, bad_seen);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", expected_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
